FILE: hdl/grid_ray_cast_free_marking_macros.svh
// assertion macros shared by the ray cast grid modules
`ifndef GRID_RAY_CAST_FREE_MARKING_MACROS_SVH
`define GRID_RAY_CAST_FREE_MARKING_MACROS_SVH

// same-cycle implication under active-low reset
`define GRCF_ASSERT_IMPLY(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("grcf check failed");

// next-cycle implication under active-low reset
`define GRCF_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("grcf check failed");

`endif

FILE: hdl/grcf_pkg.sv
// types and constants shared by the ray cast grid modules
`timescale 1ns / 1ps
`default_nettype none

package grcf_pkg;

    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    localparam int CELL_W  = 2;
    localparam int COORD_W = 6;
    localparam int END_W   = 8;
    localparam int WALK_W  = 9;
    localparam int DIST_W  = 8;
    localparam int ERR_W   = 12;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [CELL_W-1:0] CELL_FREE     = 2'd1;
    localparam logic [CELL_W-1:0] CELL_OBSTACLE = 2'd2;

    localparam logic [1:0] KIND_CAST  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_CAST,
        OP_WRITE,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [COORD_W-1:0]        start_x;
        logic [COORD_W-1:0]        start_y;
        logic                      start_in;
        logic signed [WALK_W-1:0]  end_x;
        logic signed [WALK_W-1:0]  end_y;
        logic [CELL_W-1:0]         cell_value;
        logic [DIST_W-1:0]         dist_x;
        logic [DIST_W-1:0]         dist_y;
        logic                      step_x_neg;
        logic                      step_y_neg;
    } q_entry_t;

endpackage

`default_nettype wire

FILE: hdl/grcf_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module grcf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/grcf_front.sv
// front end: accepts beats, classifies them and queues them for the walker
`timescale 1ns / 1ps
`default_nettype none
`include "grid_ray_cast_free_marking_macros.svh"

module grcf_front #(
    parameter int GRID_ROWS = grcf_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = grcf_pkg::GRID_COLS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_kind,
    input  wire logic [grcf_pkg::COORD_W-1:0]      s_start_x,
    input  wire logic [grcf_pkg::COORD_W-1:0]      s_start_y,
    input  wire logic signed [grcf_pkg::END_W-1:0] s_end_x,
    input  wire logic signed [grcf_pkg::END_W-1:0] s_end_y,
    input  wire logic [grcf_pkg::CELL_W-1:0]       s_cell_value,
    input  wire logic                              clr_busy,
    output logic                                   q_valid,
    output grcf_pkg::q_entry_t                     q_entry,
    input  wire logic                              q_pop
);

    localparam int PTR_W = (grcf_pkg::QUEUE_DEPTH > 1) ? $clog2(grcf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(grcf_pkg::QUEUE_DEPTH + 1);

    grcf_pkg::q_entry_t q_mem_reg [grcf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    grcf_pkg::q_entry_t cls;
    logic signed [grcf_pkg::WALK_W-1:0] diff_x, diff_y;
    logic push;

    // classify the incoming beat
    always_comb begin
        cls = '0;
        case (s_kind)
            grcf_pkg::KIND_CAST:  cls.op = grcf_pkg::OP_CAST;
            grcf_pkg::KIND_WRITE: cls.op = grcf_pkg::OP_WRITE;
            grcf_pkg::KIND_READ:  cls.op = grcf_pkg::OP_READ;
            default:              cls.op = grcf_pkg::OP_NOP;
        endcase
        cls.start_x    = s_start_x;
        cls.start_y    = s_start_y;
        cls.start_in   = ({1'b0, s_start_x} < 7'(GRID_ROWS)) &&
                         ({1'b0, s_start_y} < 7'(GRID_COLS));
        cls.end_x      = grcf_pkg::WALK_W'(s_end_x);
        cls.end_y      = grcf_pkg::WALK_W'(s_end_y);
        cls.cell_value = s_cell_value;
        diff_x = cls.end_x - $signed({3'b000, s_start_x});
        diff_y = cls.end_y - $signed({3'b000, s_start_y});
        cls.dist_x     = diff_x[grcf_pkg::WALK_W-1] ? grcf_pkg::DIST_W'(-diff_x)
                                                   : grcf_pkg::DIST_W'(diff_x);
        cls.dist_y     = diff_y[grcf_pkg::WALK_W-1] ? grcf_pkg::DIST_W'(-diff_y)
                                                   : grcf_pkg::DIST_W'(diff_y);
        // step toward the end, or down when already level
        cls.step_x_neg = diff_x[grcf_pkg::WALK_W-1] || (diff_x == '0);
        cls.step_y_neg = diff_y[grcf_pkg::WALK_W-1] || (diff_y == '0);
    end

    assign s_ready = (count_reg != CNT_W'(grcf_pkg::QUEUE_DEPTH)) && !clr_busy;
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_entry = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(grcf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(grcf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

    `GRCF_ASSERT_IMPLY(a_pop_not_empty, aclk, aresetn, q_pop, count_reg != '0)
    `GRCF_ASSERT_IMPLY(a_no_push_clearing, aclk, aresetn, clr_busy, !push)

endmodule

`default_nettype wire

FILE: hdl/grcf_back.sv
// back end: grid memory, clearing pass, line walk, write and read beats, result register
`timescale 1ns / 1ps
`default_nettype none
`include "grid_ray_cast_free_marking_macros.svh"

module grcf_back #(
    parameter int GRID_ROWS = grcf_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = grcf_pkg::GRID_COLS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    input  wire grcf_pkg::q_entry_t           q_entry,
    output logic                              q_pop,
    output logic                              clr_busy,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [grcf_pkg::COORD_W-1:0]      m_stop_x,
    output logic [grcf_pkg::COORD_W-1:0]      m_stop_y,
    output logic                              m_hit,
    output logic [grcf_pkg::CELL_W-1:0]       m_read_value
);

    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = grcf_pkg::WALK_W;
    localparam int EW    = grcf_pkg::ERR_W;
    localparam int DW    = grcf_pkg::DIST_W;
    localparam int CW    = grcf_pkg::COORD_W;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_WALK   = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_RDWAIT = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(32'(r) * 32'(GRID_COLS) + 32'(c));
    endfunction

    state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic signed [WW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [WW-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic [DW-1:0] dx_reg, dx_next, dym_reg, dym_next;
    logic stxn_reg, stxn_next, styn_reg, styn_next;
    logic rd_in_reg, rd_in_next;

    logic [CW-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic res_hit_reg, res_hit_next;
    logic [grcf_pkg::CELL_W-1:0] res_rv_reg, res_rv_next;

    logic m_valid_reg, m_valid_next;
    logic [CW-1:0] m_stop_x_reg, m_stop_y_reg;
    logic m_hit_reg;
    logic [grcf_pkg::CELL_W-1:0] m_read_value_reg;
    logic out_load;

    logic ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [grcf_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    logic [AW-1:0] cur_addr;
    logic cur_in, at_end;
    logic signed [EW:0] e2, dx_s, dy_s, err_sum;
    logic go_x, go_y;
    logic signed [WW-1:0] x_step, y_step;
    logic signed [EW-1:0] err_step;

    grcf_ram #(
        .WIDTH (grcf_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // current point and one bresenham step
    always_comb begin
        cur_addr = cell_addr(x_reg[CW-1:0], y_reg[CW-1:0]);
        cur_in   = !x_reg[WW-1] && (x_reg[WW-2:0] < (WW-1)'(GRID_ROWS)) &&
                   !y_reg[WW-1] && (y_reg[WW-2:0] < (WW-1)'(GRID_COLS));
        at_end   = (x_reg == x1_reg) && (y_reg == y1_reg);
        e2       = $signed({err_reg, 1'b0});
        dx_s     = $signed({{(EW + 1 - DW){1'b0}}, dx_reg});
        dy_s     = -$signed({{(EW + 1 - DW){1'b0}}, dym_reg});
        go_x     = (e2 >= dy_s);
        go_y     = (e2 <= dx_s);
        err_sum  = {err_reg[EW-1], err_reg} + (go_x ? dy_s : '0) + (go_y ? dx_s : '0);
        err_step = err_sum[EW-1:0];
        x_step   = go_x ? (stxn_reg ? x_reg - WW'(1) : x_reg + WW'(1)) : x_reg;
        y_step   = go_y ? (styn_reg ? y_reg - WW'(1) : y_reg + WW'(1)) : y_reg;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        err_next     = err_reg;
        dx_next      = dx_reg;
        dym_next     = dym_reg;
        stxn_next    = stxn_reg;
        styn_next    = styn_reg;
        rd_in_next   = rd_in_reg;
        res_x_next   = res_x_reg;
        res_y_next   = res_y_reg;
        res_hit_next = res_hit_reg;
        res_rv_next  = res_rv_reg;
        ram_we       = 1'b0;
        ram_waddr    = cur_addr;
        ram_wdata    = grcf_pkg::CELL_FREE;
        ram_re       = 1'b0;
        ram_raddr    = cur_addr;
        q_pop        = 1'b0;
        out_load     = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = grcf_pkg::CELL_UNKNOWN;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    res_x_next   = '0;
                    res_y_next   = '0;
                    res_hit_next = 1'b0;
                    res_rv_next  = grcf_pkg::CELL_UNKNOWN;
                    case (q_entry.op)
                        grcf_pkg::OP_CAST: begin
                            x_next     = $signed(WW'(q_entry.start_x));
                            y_next     = $signed(WW'(q_entry.start_y));
                            x1_next    = q_entry.end_x;
                            y1_next    = q_entry.end_y;
                            dx_next    = q_entry.dist_x;
                            dym_next   = q_entry.dist_y;
                            stxn_next  = q_entry.step_x_neg;
                            styn_next  = q_entry.step_y_neg;
                            err_next   = $signed(EW'(q_entry.dist_x)) -
                                         $signed(EW'(q_entry.dist_y));
                            res_x_next = q_entry.start_x;
                            res_y_next = q_entry.start_y;
                            state_next = ST_WALK;
                        end
                        grcf_pkg::OP_WRITE: begin
                            ram_we     = q_entry.start_in;
                            ram_waddr  = cell_addr(q_entry.start_x, q_entry.start_y);
                            ram_wdata  = q_entry.cell_value;
                            state_next = ST_DONE;
                        end
                        grcf_pkg::OP_READ: begin
                            ram_re     = q_entry.start_in;
                            ram_raddr  = cell_addr(q_entry.start_x, q_entry.start_y);
                            rd_in_next = q_entry.start_in;
                            state_next = ST_RDWAIT;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (cur_in) begin
                    ram_re     = 1'b1;
                    state_next = ST_CHECK;
                end else if (at_end) begin
                    state_next = ST_DONE;
                end else begin
                    x_next   = x_step;
                    y_next   = y_step;
                    err_next = err_step;
                end
            end
            ST_CHECK: begin
                res_x_next = x_reg[CW-1:0];
                res_y_next = y_reg[CW-1:0];
                if (ram_rdata == grcf_pkg::CELL_OBSTACLE) begin
                    res_hit_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    ram_we = 1'b1;
                    if (at_end) begin
                        state_next = ST_DONE;
                    end else begin
                        x_next     = x_step;
                        y_next     = y_step;
                        err_next   = err_step;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_RDWAIT: begin
                res_rv_next = rd_in_reg ? ram_rdata : grcf_pkg::CELL_UNKNOWN;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        err_reg     <= err_next;
        dx_reg      <= dx_next;
        dym_reg     <= dym_next;
        stxn_reg    <= stxn_next;
        styn_reg    <= styn_next;
        rd_in_reg   <= rd_in_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_hit_reg <= res_hit_next;
        res_rv_reg  <= res_rv_next;
        if (out_load) begin
            m_stop_x_reg     <= res_x_reg;
            m_stop_y_reg     <= res_y_reg;
            m_hit_reg        <= res_hit_reg;
            m_read_value_reg <= res_rv_reg;
        end
    end

    assign clr_busy     = (state_reg == ST_CLEAR);
    assign m_valid      = m_valid_reg;
    assign m_stop_x     = m_stop_x_reg;
    assign m_stop_y     = m_stop_y_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;

    `GRCF_ASSERT_IMPLY(a_no_pop_clearing, aclk, aresetn, state_reg == ST_CLEAR, !q_pop)
    `GRCF_ASSERT_IMPLY(a_obstacle_kept, aclk, aresetn,
        (state_reg == ST_CHECK) && (ram_rdata == grcf_pkg::CELL_OBSTACLE), !ram_we)
    `GRCF_ASSERT_IMPLY(a_hit_no_value, aclk, aresetn,
        m_valid_reg && m_hit_reg, m_read_value_reg == grcf_pkg::CELL_UNKNOWN)
    `GRCF_ASSERT_NEXT(a_load_valid, aclk, aresetn, out_load, m_valid_reg)

endmodule

`default_nettype wire

FILE: hdl/grid_ray_cast_free_marking.sv
// top level of the occupancy grid ray caster with free-space marking
//
//   channel | ports                                         | dir | handshake
//   --------+-----------------------------------------------+-----+--------------------
//   input   | s_kind s_start_x s_start_y s_end_x s_end_y    | in  | s_valid / s_ready
//           | s_cell_value                                  |     |
//   result  | m_stop_x m_stop_y m_hit m_read_value          | out | m_valid / m_ready
//
// cast: each in-grid point is read, then marked free unless an obstacle ends the ray;
//   off-grid points are stepped over; dispatch precedes the walk, a result load follows
// write and read beats also use the single grid ram port pair, which sets the pace
// after reset all GRID_ROWS * GRID_COLS cells (4096) are set to unknown, s_ready low
// a two-beat queue lets the front accept while the walker or the result register stalls
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_cast_free_marking #(
    parameter int GRID_ROWS = grcf_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = grcf_pkg::GRID_COLS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_kind,
    input  wire logic [grcf_pkg::COORD_W-1:0]      s_start_x,
    input  wire logic [grcf_pkg::COORD_W-1:0]      s_start_y,
    input  wire logic signed [grcf_pkg::END_W-1:0] s_end_x,
    input  wire logic signed [grcf_pkg::END_W-1:0] s_end_y,
    input  wire logic [grcf_pkg::CELL_W-1:0]       s_cell_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [grcf_pkg::COORD_W-1:0]           m_stop_x,
    output logic [grcf_pkg::COORD_W-1:0]           m_stop_y,
    output logic                                   m_hit,
    output logic [grcf_pkg::CELL_W-1:0]            m_read_value
);

    logic               q_valid;
    logic               q_pop;
    logic               clr_busy;
    grcf_pkg::q_entry_t q_entry;

    grcf_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_cell_value (s_cell_value),
        .clr_busy     (clr_busy),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    grcf_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .clr_busy     (clr_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_stop_x     (m_stop_x),
        .m_stop_y     (m_stop_y),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

endmodule

`default_nettype wire
